// File: hdl/rv64c_pkg.sv
// shared constants, codes and beat types of the rv64 subset core
package rv64c_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int AW        = $clog2(MEM_BYTES);
  localparam int UW        = AW + 1;
  localparam int ROWS      = MEM_BYTES / 8;
  localparam int RW        = $clog2(ROWS);
  localparam int XW        = 18;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_DWRITE = 2'd1;
  localparam logic [1:0] MODE_STEP   = 2'd2;
  localparam logic [1:0] MODE_RDREG  = 2'd3;

  localparam logic [6:0] OPC_R  = 7'd51;
  localparam logic [6:0] OPC_I  = 7'd19;
  localparam logic [6:0] OPC_LD = 7'd3;
  localparam logic [6:0] OPC_SD = 7'd35;
  localparam logic [6:0] OPC_BR = 7'd99;

  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [63:0] data_value;
    logic [4:0]  reg_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pc_now;
    logic        executed;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [63:0] write_value;
    logic        running;
    logic [63:0] read_value;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          wr_long;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
  } mem_req_t;

endpackage

// File: hdl/rv64c_front.sv
// front end: two-entry queue of accepted input beats
module rv64c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rv64c_pkg::in_item_t in_item,
  output logic                q_valid,
  output rv64c_pkg::in_item_t q_item,
  input  logic                q_pop
);

  rv64c_pkg::in_item_t slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: hdl/rv64c_mem.sv
// eight byte-wide banks forming the unified byte memory, with clearing pass
module rv64c_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  rv64c_pkg::mem_req_t req,
  output logic [63:0]         rd_data,
  output logic                busy
);

  localparam int RW = rv64c_pkg::RW;
  localparam int AW = rv64c_pkg::AW;

  logic [7:0]    q [8];
  logic [2:0]    ra_lo_r;
  logic [RW-1:0] clr_r;
  logic          busy_r;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == RW'(rv64c_pkg::ROWS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]    mem [rv64c_pkg::ROWS];
    logic [2:0]    wi;
    logic [2:0]    ri;
    logic [AW:0]   wsum;
    logic [AW:0]   rsum;
    logic          wen;

    assign wi   = 3'(b) - req.wr_addr[2:0];
    assign ri   = 3'(b) - req.rd_addr[2:0];
    assign wsum = {1'b0, req.wr_addr} + (AW+1)'(wi);
    assign rsum = {1'b0, req.rd_addr} + (AW+1)'(ri);
    assign wen  = req.wr_en && (req.wr_long || !wi[2]);

    always_ff @(posedge clk) begin
      if (busy_r) begin
        mem[clr_r] <= 8'h00;
      end else if (wen) begin
        mem[wsum[AW-1:3]] <= req.wr_data[8*wi +: 8];
      end
      q[b] <= mem[rsum[AW-1:3]];
    end
  end

  always_ff @(posedge clk) begin
    ra_lo_r <= req.rd_addr[2:0];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rd_data[8*i +: 8] = q[3'(ra_lo_r + 3'(i))];
    end
  end

endmodule

// File: hdl/rv64c_back.sv
// back end: step sequencer, register file and result queue
module rv64c_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rv64c_pkg::in_item_t  q_item,
  output logic                 q_pop,
  output rv64c_pkg::mem_req_t  mreq,
  input  logic [63:0]          mem_rdata,
  input  logic                 mem_busy,
  output logic                 out_empty,
  input  logic                 out_pop,
  output rv64c_pkg::out_item_t out_item
);

  localparam int XW = rv64c_pkg::XW;
  localparam int UW = rv64c_pkg::UW;
  localparam int AW = rv64c_pkg::AW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDREG = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_RUN   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;

  logic [3:0]    state_r;
  logic [63:0]   pc_r;
  logic [UW-1:0] used_r;
  logic [31:0]   ins_r;
  logic [63:0]   alu_r;
  logic [63:0]   ea_r;
  logic [63:0]   br_r;
  logic          neq_r;
  logic [63:0]   st_r;
  rv64c_pkg::out_item_t res_r;

  // register file, two registered read ports
  logic [63:0] rf [32];
  logic [31:0] rf_vld_r;
  logic [4:0]  ra_a;
  logic [4:0]  ra_b;
  logic [63:0] rq_a_r;
  logic [63:0] rq_b_r;
  logic        rv_a_r;
  logic        rv_b_r;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [63:0] rf_wd;

  // result queue
  rv64c_pkg::out_item_t oq_r [2];
  logic       oq_wp_r;
  logic       oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic       oq_push;
  logic       oq_pop;
  rv64c_pkg::out_item_t oq_din;

  logic        start;
  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [63:0] imm_i;
  logic [63:0] imm_s;
  logic [63:0] imm_b;
  logic [63:0] op2;
  logic [63:0] pc4;
  logic        fetch_ok;
  logic        app_ok;
  logic        dw_ok;
  logic        ld_ok;
  logic        sd_ok;
  logic [XW-1:0] dw_end;
  logic [XW-1:0] ea_end;

  assign start  = (state_r == S_IDLE) && q_valid && !mem_busy && (oq_cnt_r != 2'd2);
  assign q_pop  = start;

  assign opc   = ins_r[6:0];
  assign rd    = ins_r[11:7];
  assign f3    = ins_r[14:12];
  assign imm_i = {{52{ins_r[31]}}, ins_r[31:20]};
  assign imm_s = {{52{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign imm_b = {{51{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign op_a  = rv_a_r ? rq_a_r : 64'd0;
  assign op_b  = rv_b_r ? rq_b_r : 64'd0;
  assign op2   = (opc == rv64c_pkg::OPC_R) ? op_b : imm_i;
  assign pc4   = pc_r + 64'd4;

  assign fetch_ok = (pc_r[63:XW-1] == '0) &&
                    ({1'b0, pc_r[XW-2:0]} + XW'(4) <= XW'(used_r));
  assign app_ok   = XW'(used_r) + XW'(4) <= XW'(rv64c_pkg::MEM_BYTES);
  assign dw_end   = XW'(q_item.address) + XW'(8);
  assign dw_ok    = dw_end <= XW'(rv64c_pkg::MEM_BYTES);
  assign ea_end   = {1'b0, ea_r[XW-2:0]} + XW'(8);
  assign ld_ok    = (ea_r[63:XW-1] == '0) && (ea_end <= XW'(used_r));
  assign sd_ok    = (ea_r[63:XW-1] == '0) && (ea_end <= XW'(rv64c_pkg::MEM_BYTES));

  // read port addresses and memory requests by state
  always_comb begin
    ra_a         = 5'd0;
    ra_b         = 5'd0;
    mreq         = '0;
    rf_we        = 1'b0;
    rf_wa        = rd;
    rf_wd        = alu_r;
    unique case (state_r)
      S_IDLE: begin
        ra_a = q_item.reg_index;
        if (start) begin
          unique case (q_item.mode)
            rv64c_pkg::MODE_APPEND: begin
              mreq.wr_en   = app_ok;
              mreq.wr_long = 1'b0;
              mreq.wr_addr = used_r[AW-1:0];
              mreq.wr_data = q_item.data_value;
            end
            rv64c_pkg::MODE_DWRITE: begin
              mreq.wr_en   = dw_ok;
              mreq.wr_long = 1'b1;
              mreq.wr_addr = AW'(q_item.address);
              mreq.wr_data = q_item.data_value;
            end
            rv64c_pkg::MODE_STEP: begin
              mreq.rd_addr = pc_r[AW-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        ra_a = mem_rdata[19:15];
        ra_b = mem_rdata[24:20];
      end
      S_WB: begin
        if (opc == rv64c_pkg::OPC_R || opc == rv64c_pkg::OPC_I) begin
          rf_we = (rd != 5'd0);
          rf_wd = alu_r;
        end else if (opc == rv64c_pkg::OPC_LD) begin
          mreq.rd_addr = ea_r[AW-1:0];
          rf_we        = !ld_ok && (rd != 5'd0);
          rf_wd        = 64'd0;
        end else if (opc == rv64c_pkg::OPC_SD) begin
          mreq.wr_en   = sd_ok;
          mreq.wr_long = 1'b1;
          mreq.wr_addr = ea_r[AW-1:0];
          mreq.wr_data = st_r;
        end
      end
      S_LOAD: begin
        rf_we = (rd != 5'd0);
        rf_wd = mem_rdata;
      end
      S_RUN: begin
        mreq.rd_addr = pc_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    rq_a_r <= rf[ra_a];
    rq_b_r <= rf[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rv_a_r   <= 1'b0;
      rv_b_r   <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
      end
      rv_a_r <= rf_vld_r[ra_a];
      rv_b_r <= rf_vld_r[ra_b];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_FETCH: begin
        ins_r <= mem_rdata[31:0];
      end
      S_EXEC: begin
        if (opc == rv64c_pkg::OPC_R && ins_r[30]) begin
          alu_r <= op_a - op2;
        end else if (f3 == rv64c_pkg::F3_OR) begin
          alu_r <= op_a | op2;
        end else if (f3 == rv64c_pkg::F3_AND) begin
          alu_r <= op_a & op2;
        end else begin
          alu_r <= op_a + op2;
        end
        ea_r  <= op_a + ((opc == rv64c_pkg::OPC_SD) ? imm_s : imm_i);
        br_r  <= pc_r + imm_b;
        neq_r <= (op_a != op_b);
        st_r  <= op_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      used_r  <= '0;
      res_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            res_r <= '0;
            unique case (q_item.mode)
              rv64c_pkg::MODE_APPEND: begin
                if (app_ok) begin
                  used_r <= used_r + UW'(4);
                end else begin
                  res_r.out_of_range <= 1'b1;
                end
                state_r <= S_RUN;
              end
              rv64c_pkg::MODE_DWRITE: begin
                if (dw_ok) begin
                  if (dw_end > XW'(used_r)) begin
                    used_r <= UW'(dw_end);
                  end
                end else begin
                  res_r.out_of_range <= 1'b1;
                end
                state_r <= S_RUN;
              end
              rv64c_pkg::MODE_STEP: begin
                state_r <= fetch_ok ? S_FETCH : S_RUN;
              end
              default: begin
                state_r <= S_RDREG;
              end
            endcase
          end
        end
        S_RDREG: begin
          res_r.read_value <= op_a;
          state_r          <= S_RUN;
        end
        S_FETCH: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          res_r.executed <= 1'b1;
          res_r.dest_reg <= rd;
          state_r        <= S_WB;
        end
        S_WB: begin
          state_r <= S_RUN;
          pc_r    <= pc4;
          if (opc == rv64c_pkg::OPC_R || opc == rv64c_pkg::OPC_I) begin
            res_r.write_value <= alu_r;
            res_r.reg_written <= (rd != 5'd0);
          end else if (opc == rv64c_pkg::OPC_LD) begin
            res_r.reg_written <= (rd != 5'd0);
            if (ld_ok) begin
              state_r <= S_LOAD;
            end
          end else if (opc == rv64c_pkg::OPC_SD) begin
            if (sd_ok) begin
              if (ea_end > XW'(used_r)) begin
                used_r <= UW'(ea_end);
              end
            end else begin
              res_r.out_of_range <= 1'b1;
            end
          end else if (opc == rv64c_pkg::OPC_BR) begin
            if (neq_r) begin
              pc_r <= br_r;
            end
          end
        end
        S_LOAD: begin
          res_r.write_value <= mem_rdata;
          state_r           <= S_RUN;
        end
        S_RUN: begin
          res_r.running <= 1'b0;
          state_r       <= fetch_ok ? S_RWAIT : S_IDLE;
        end
        S_RWAIT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result beat goes out after the look-ahead fetch, if any
  assign oq_push = (state_r == S_RWAIT) || (state_r == S_RUN && !fetch_ok);
  always_comb begin
    oq_din        = res_r;
    oq_din.pc_now = pc_r;
    oq_din.running = (state_r == S_RWAIT) && (mem_rdata[31:0] != 32'd0);
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_item  = oq_r[oq_rp_r];
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= ~oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= ~oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

`ifndef SYNTH
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_wa != 5'd0))
    else $error("register write to x0");
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_en |-> !mem_busy)
    else $error("memory write during clearing pass");
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r != 2'd2) || oq_pop)
    else $error("result queue overflow");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r != S_IDLE))
    else $error("sequencer did not leave idle after start");
`endif

endmodule

// File: hdl/rv64_single_cycle_core.sv
// top level of the rv64 subset core: front queue, byte memory, step sequencer
// Usage:
//   Input beats are pushed with in_push while in_full is low; each beat carries
//   mode, address, data_value and reg_index (append word, write doubleword,
//   execute one instruction, read register).
//   Result beats wait in a two-entry queue; the oldest is on out_item while
//   out_empty is low and leaves with out_pop. Exactly one result per input beat.
//   Items are worked one at a time by the sequencer, from queue head to result
//   queue: an executed step passes fetch, execute and writeback, and a load also
//   a load state; a register read passes a read state. Every item ends with a
//   look-ahead fetch at the new pc, skipped when the new pc lies past the used
//   range. The memory's single registered read port serves the instruction
//   fetch, the load and the look-ahead fetch at the new pc.
//   Up to two input beats queue while a step runs, so the source can keep
//   pushing; when the receiver stalls the result queue fills and the sequencer
//   stops taking items once it holds two results.
//   After reset the byte memory is cleared one 8-byte row per cycle, all 512
//   rows, before the first item is started; input beats are still queued.
module rv64_single_cycle_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  rv64c_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output rv64c_pkg::out_item_t out_item
);

  logic                q_valid;
  logic                q_pop;
  rv64c_pkg::in_item_t q_item;
  rv64c_pkg::mem_req_t mreq;
  logic [63:0]         mem_rdata;
  logic                mem_busy;

  rv64c_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rv64c_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (mem_rdata),
    .busy    (mem_busy)
  );

  rv64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .mreq      (mreq),
    .mem_rdata (mem_rdata),
    .mem_busy  (mem_busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: verif/rv64_core_checker.sv
// beat checker for the rv64 subset core: predicts each result and compares it
module rv64_core_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  rv64c_pkg::in_item_t  in_item,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  rv64c_pkg::out_item_t out_item,
  output int                   errors,
  output int                   pending
);

  localparam int MEM_BYTES = rv64c_pkg::MEM_BYTES;

  logic [7:0]  mem_bytes [MEM_BYTES];
  logic [63:0] xregs [32];
  logic [63:0] pc;
  logic [12:0] used;
  rv64c_pkg::out_item_t result_q [$];

  function automatic logic [63:0] get_bytes(logic [63:0] addr, int n);
    logic [63:0] v;
    logic [11:0] idx;
    v = '0;
    for (int i = 0; i < n; i++) begin
      idx = addr[11:0] + 12'(i);
      v |= {56'b0, mem_bytes[idx]} << (8 * i);
    end
    return v;
  endfunction

  function automatic bit put_dword(logic [63:0] addr, logic [63:0] val);
    if (addr > 64'(MEM_BYTES - 8)) return 0;
    for (int i = 0; i < 8; i++) mem_bytes[addr + i] = val[8*i +: 8];
    if (addr + 8 > {51'b0, used}) used = 13'(addr + 8);
    return 1;
  endfunction

  function automatic bit fetch_ok();
    return used >= 4 && pc <= {51'b0, used} - 64'd4;
  endfunction

  function automatic logic [63:0] sx12(logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  function automatic rv64c_pkg::out_item_t next_result(rv64c_pkg::in_item_t it);
    rv64c_pkg::out_item_t r;
    logic [31:0] ins;
    logic [63:0] a, b, nxt, res, ea, op2;
    logic [12:0] boff;
    bit          wb;
    r = '0;
    case (it.mode)
      rv64c_pkg::MODE_APPEND: begin
        if (int'(used) + 4 <= MEM_BYTES) begin
          for (int i = 0; i < 4; i++) mem_bytes[used + i] = it.data_value[8*i +: 8];
          used += 4;
        end else begin
          r.out_of_range = 1;
        end
      end
      rv64c_pkg::MODE_DWRITE: begin
        if (!put_dword({52'b0, it.address}, it.data_value)) r.out_of_range = 1;
      end
      rv64c_pkg::MODE_STEP: begin
        if (fetch_ok()) begin
          ins = get_bytes(pc, 4);
          a = xregs[ins[19:15]];
          b = xregs[ins[24:20]];
          nxt = pc + 4;
          wb = 0;
          res = '0;
          r.executed = 1;
          r.dest_reg = ins[11:7];
          if (ins[6:0] == rv64c_pkg::OPC_R || ins[6:0] == rv64c_pkg::OPC_I) begin
            op2 = (ins[6:0] == rv64c_pkg::OPC_R) ? b : sx12(ins[31:20]);
            if (ins[6:0] == rv64c_pkg::OPC_R && ins[30]) res = a - op2;
            else if (ins[14:12] == rv64c_pkg::F3_OR)      res = a | op2;
            else if (ins[14:12] == rv64c_pkg::F3_AND)     res = a & op2;
            else                                          res = a + op2;
            wb = 1;
          end else if (ins[6:0] == rv64c_pkg::OPC_LD) begin
            ea = a + sx12(ins[31:20]);
            if (used >= 8 && ea <= {51'b0, used} - 64'd8) res = get_bytes(ea, 8);
            wb = 1;
          end else if (ins[6:0] == rv64c_pkg::OPC_SD) begin
            if (!put_dword(a + sx12({ins[31:25], ins[11:7]}), b)) r.out_of_range = 1;
          end else if (ins[6:0] == rv64c_pkg::OPC_BR) begin
            boff = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            if (a != b) nxt = pc + {{51{boff[12]}}, boff};
          end
          if (wb) begin
            r.write_value = res;
            if (ins[11:7] != 0) begin
              xregs[ins[11:7]] = res;
              r.reg_written = 1;
            end
          end
          pc = nxt;
        end
      end
      default: r.read_value = xregs[it.reg_index];
    endcase
    r.running = fetch_ok() && get_bytes(pc, 4) != 0;
    r.pc_now = pc;
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    rv64c_pkg::out_item_t w;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) mem_bytes[i] = '0;
      for (int i = 0; i < 32; i++) xregs[i] = '0;
      pc = '0;
      used = '0;
      result_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (result_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          w = result_q.pop_front();
          check_field("pc_now", out_item.pc_now, w.pc_now);
          check_field("executed", out_item.executed, w.executed);
          check_field("reg_written", out_item.reg_written, w.reg_written);
          check_field("dest_reg", out_item.dest_reg, w.dest_reg);
          check_field("write_value", out_item.write_value, w.write_value);
          check_field("running", out_item.running, w.running);
          check_field("read_value", out_item.read_value, w.read_value);
          check_field("out_of_range", out_item.out_of_range, w.out_of_range);
        end
      end
      if (in_push && !in_full) result_q = {result_q, next_result(in_item)};
    end
    pending = result_q.size();
  end

endmodule

// File: verif/tb_rv64_single_cycle_core.sv
// testbench top for the rv64 subset core: program stimulus, idling and verdict
module tb_rv64_single_cycle_core;

  localparam int QUIET_LIMIT = 4000;
  localparam int N_ITEMS     = 1300;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_push = 0;
  logic                 in_full;
  rv64c_pkg::in_item_t  in_item = '0;
  logic                 out_empty;
  logic                 out_pop = 0;
  rv64c_pkg::out_item_t out_item;
  int        errors, pending;
  int        sent = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        prog_bytes = 0;
  int        quiet = 0;

  rv64_single_cycle_core u_top (
    .clk, .rst_n, .in_push, .in_full, .in_item, .out_empty, .out_pop, .out_item
  );

  rv64_core_checker u_chk (
    .clk, .rst_n, .in_push, .in_full, .in_item, .out_empty, .out_pop, .out_item,
    .errors, .pending
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 0;
    else out_pop <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] r_word(bit b30, int rs2, int rs1, int f3, int rd);
    return {1'b0, b30, 5'b0, 5'(rs2), 5'(rs1), 3'(f3), 5'(rd), rv64c_pkg::OPC_R};
  endfunction

  function automatic logic [31:0] i_word(logic [6:0] opc, int imm, int rs1, int f3, int rd);
    return {12'(imm), 5'(rs1), 3'(f3), 5'(rd), opc};
  endfunction

  function automatic logic [31:0] s_word(int imm, int rs2, int rs1, int f3);
    logic [11:0] m;
    m = 12'(imm);
    return {m[11:5], 5'(rs2), 5'(rs1), 3'(f3), m[4:0], rv64c_pkg::OPC_SD};
  endfunction

  function automatic logic [31:0] b_word(int off, int rs2, int rs1, int f3);
    logic [12:0] m;
    m = 13'(off);
    return {m[12], m[10:5], 5'(rs2), 5'(rs1), 3'(f3), m[4:1], m[11], rv64c_pkg::OPC_BR};
  endfunction

  // mostly small registers so results feed later instructions
  function automatic int pick_reg();
    return ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(7);
  endfunction

  function automatic logic [31:0] rand_insn();
    case ($urandom_range(9))
      0, 1: return r_word($urandom_range(1), pick_reg(), pick_reg(), $urandom_range(7),
                          pick_reg());
      2, 3: return i_word(rv64c_pkg::OPC_I, $urandom_range(4095), pick_reg(),
                          $urandom_range(7), pick_reg());
      4:    return i_word(rv64c_pkg::OPC_LD, $urandom_range(2047),
                          $urandom_range(1) ? 0 : pick_reg(), $urandom_range(7), pick_reg());
      5:    return s_word($urandom_range(prog_bytes + 64), pick_reg(),
                          $urandom_range(1) ? 0 : pick_reg(), $urandom_range(7));
      6:    return b_word($urandom_range(3) == 0 ? -4 * $urandom_range(1, 3)
                          : 4 * $urandom_range(1, 4), pick_reg(), pick_reg(), $urandom_range(7));
      7:    return 32'b0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(logic [1:0] mode, logic [11:0] addr, logic [63:0] data, logic [4:0] ridx);
    rv64c_pkg::in_item_t it;
    int                  ph;
    it.mode = mode;
    it.address = addr;
    it.data_value = data;
    it.reg_index = ridx;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_push <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    sent++;
    ph = (sent / 150) % 4;
    idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 6 : 0;
    stall_pct = (ph == 2) ? 49 : (ph == 3) ? 6 : 0;
  endtask

  task automatic append(logic [31:0] w);
    send(rv64c_pkg::MODE_APPEND, 12'($urandom()), {$urandom(), w}, 5'($urandom()));
    prog_bytes += 4;
  endtask

  task automatic step();
    send(rv64c_pkg::MODE_STEP, 12'($urandom()), {$urandom(), $urandom()}, 5'($urandom()));
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed program: every alu form, store and load out of range, taken branch
    append(i_word(rv64c_pkg::OPC_I, -1, 0, 0, 1));
    append(i_word(rv64c_pkg::OPC_I, 2047, 0, 0, 2));
    append(r_word(0, 2, 1, 0, 3));
    append(r_word(1, 1, 2, 0, 4));
    append(r_word(0, 2, 1, rv64c_pkg::F3_AND, 5));
    append(r_word(0, 2, 1, rv64c_pkg::F3_OR, 6));
    append(r_word(0, 1, 1, 2, 7));
    append(i_word(rv64c_pkg::OPC_I, -2048, 1, rv64c_pkg::F3_OR, 8));
    append(r_word(0, 1, 1, 0, 0));
    append(s_word(2047, 1, 2, 3));
    append(i_word(rv64c_pkg::OPC_LD, 2047, 2, 5, 9));
    append(32'b0);
    append(32'h0000_007f);
    append(b_word(8, 2, 1, 1));
    append(32'hffff_ffff);
    repeat (16) step();
    send(rv64c_pkg::MODE_RDREG, '0, '0, 5'd0);
    send(rv64c_pkg::MODE_RDREG, '1, '1, 5'd31);
    send(rv64c_pkg::MODE_DWRITE, 12'd64, 64'hffff_ffff_ffff_ffff, '0);

    // random programs: a burst of appends, then mostly steps, mixed with other items, running through them
    while (sent < N_ITEMS) begin
      n = $urandom_range(1, 8);
      repeat (n) append(rand_insn());
      repeat (n + $urandom_range(0, 2)) begin
        case ($urandom_range(11))
          0: send(rv64c_pkg::MODE_RDREG, 12'($urandom()), {$urandom(), $urandom()},
                  5'($urandom()));
          1: send(rv64c_pkg::MODE_DWRITE, 12'($urandom_range(prog_bytes)),
                  {$urandom(), $urandom()}, 5'($urandom()));
          2: send(2'($urandom()), 12'($urandom_range(prog_bytes)), {$urandom(), $urandom()},
                  5'($urandom()));
          default: step();
        endcase
      end
    end

    // upper addresses fill the memory, then appends are dropped
    send(rv64c_pkg::MODE_DWRITE, 12'd4088, 64'h8000_0000_0000_0001, '0);
    send(rv64c_pkg::MODE_DWRITE, 12'd4095, '1, '0);
    repeat (20) send(rv64c_pkg::MODE_DWRITE, 12'($urandom()), {$urandom(), $urandom()},
                     5'($urandom()));
    repeat (3) append($urandom());
    repeat (4) step();
    for (int i = 0; i < 32; i++) send(rv64c_pkg::MODE_RDREG, '0, '0, 5'(i));
    in_push <= 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
